// ===== hdl/dif_pkg.sv =====
package dif_pkg;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MAG   = 7'b0000010,
		ST_CONV  = 7'b0000100,
		ST_NORM  = 7'b0001000,
		ST_PREP  = 7'b0010000,
		ST_BOUND = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		LEN_SHORT = 2'd0,
		LEN_INT   = 2'd1,
		LEN_LONG  = 2'd2
	} len_mode_t;

	localparam logic [2:0] CFG_FIELD_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_MIN_DIGITS   = 3'd1;
	localparam logic [2:0] CFG_LEFT_JUSTIFY = 3'd2;
	localparam logic [2:0] CFG_FORCE_PLUS   = 3'd3;
	localparam logic [2:0] CFG_SPACE_SIGN   = 3'd4;
	localparam logic [2:0] CFG_ZERO_PAD     = 3'd5;
	localparam logic [2:0] CFG_LENGTH_MODE  = 3'd6;
	localparam logic [2:0] CFG_SIGNED_MODE  = 3'd7;

	localparam int ARG_W      = 64;
	localparam int CFG_W      = 7;
	localparam int BCD_DIGITS = 20;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int NDIG_W     = 5;
	localparam int ITER_W     = 7;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [7:0] ASCII_PLUS  = 8'h2b;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

endpackage

// ===== hdl/decimal_integer_field_formatter.sv =====
// channel | signals                                   | beat
// --------+-------------------------------------------+-----------------------------
// in      | in_valid, in_ready, arg_bits              | one integer argument
// out     | out_valid, out_ready, out_char, last_char | one character, last marked
// cfg     | cfg_we, cfg_idx, cfg_data                 | one register write, no wait
//
// Each item runs through these steps from one accept to the next: the accept, one
// magnitude step, 16/32/64 double-dabble shifts for short/int/long, the normalize
// step (up to 19 leading-zero shifts), two sizing steps (PREP, BOUND) and C characters
// at one per cycle unless the output stalls (C <= MAX_FIELD).
// in_ready is high only when idle; a pending last character does not block it.
// Output stalls hold the character register and pause emission.
// Reset (arst_n, async low) clears control and loads register defaults.
module decimal_integer_field_formatter #(
	parameter int MAX_FIELD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] arg_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last_char,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [6:0]  cfg_data
);

	localparam int PW = $clog2(MAX_FIELD + 1);
	localparam int CW = (PW > dif_pkg::CFG_W) ? PW : dif_pkg::CFG_W;
	localparam int BW = dif_pkg::BCD_W;

	dif_pkg::state_t state_q;

	logic [6:0] fw_q;
	logic [6:0] md_q;
	logic       lj_q, fp_q, ss_q, zp_q, sm_q;
	logic [1:0] lm_q;

	logic [dif_pkg::ARG_W-1:0]  arg_q, bin_q;
	logic [BW-1:0]              bcd_q;
	logic [dif_pkg::ITER_W-1:0] iter_q;
	logic [dif_pkg::NDIG_W-1:0] ndig_q;
	logic                       neg_q;

	logic [PW-1:0] pad_q, body_q;
	logic          signlen_q, zfill_q;
	logic [7:0]    sign_char_q;
	logic [PW-1:0] b_lead_q, b_zero_q, b_dig_q, b_trail_q, b_end_q;
	logic [PW-1:0] pos_q;

	logic       out_valid_q, last_q;
	logic [7:0] char_q;

	// magnitude and alignment
	logic [63:0]                trunc, negv, magv, aligned;
	logic                       neg_w;
	logic [dif_pkg::ITER_W-1:0] iters;

	always_comb begin
		case (lm_q)
			dif_pkg::LEN_SHORT: begin
				trunc = {48'b0, arg_q[15:0]};
				neg_w = sm_q & arg_q[15];
			end
			dif_pkg::LEN_INT: begin
				trunc = {32'b0, arg_q[31:0]};
				neg_w = sm_q & arg_q[31];
			end
			default: begin
				trunc = arg_q;
				neg_w = sm_q & arg_q[63];
			end
		endcase
		negv = ~trunc + 64'd1;
		magv = neg_w ? negv : trunc;
		case (lm_q)
			dif_pkg::LEN_SHORT: begin
				aligned = {magv[15:0], 48'b0};
				iters   = dif_pkg::ITER_W'(16);
			end
			dif_pkg::LEN_INT: begin
				aligned = {magv[31:0], 32'b0};
				iters   = dif_pkg::ITER_W'(32);
			end
			default: begin
				aligned = magv;
				iters   = dif_pkg::ITER_W'(64);
			end
		endcase
	end

	// double-dabble step
	logic [BW-1:0] adj;
	logic [BW-1:0] bcd_n;
	logic [63:0]   bin_n;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < dif_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
		end
		{bcd_n, bin_n} = {adj[BW-2:0], bin_q, 1'b0};
	end

	logic [3:0] top_dig;
	assign top_dig = bcd_q[BW-1 -: 4];

	// field sizing
	logic          signlen_w;
	logic [CW-1:0] cap_w, prec_w, body_w, total_w, width_w, pad_w, ndig_c;

	always_comb begin
		signlen_w = sm_q & (neg_q | fp_q | ss_q);
		ndig_c    = CW'(ndig_q);
		cap_w     = CW'(MAX_FIELD) - CW'(signlen_w);
		if (md_q[6])
			prec_w = '0;
		else if (CW'(md_q[5:0]) > cap_w)
			prec_w = cap_w;
		else
			prec_w = CW'(md_q[5:0]);
		body_w  = (prec_w > ndig_c) ? prec_w : ndig_c;
		total_w = body_w + CW'(signlen_w);
		width_w = (CW'(fw_q) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(fw_q);
		pad_w   = (width_w > total_w) ? width_w - total_w : '0;
	end

	logic [PW-1:0] lead_w, zeros_w, bzero_w, bdig_w, btrail_w;

	always_comb begin
		lead_w   = (!lj_q && !zfill_q) ? pad_q : '0;
		zeros_w  = (zfill_q ? pad_q : '0) + (body_q - PW'(ndig_q));
		bzero_w  = lead_w + PW'(signlen_q);
		bdig_w   = bzero_w + zeros_w;
		btrail_w = bdig_w + PW'(ndig_q);
	end

	logic       load_out;
	logic       is_last;
	logic       is_digit;
	logic [7:0] char_w;

	assign load_out = (state_q == dif_pkg::ST_EMIT) && (!out_valid_q || out_ready);
	assign is_last  = (pos_q == b_end_q - PW'(1));
	assign is_digit = (pos_q >= b_dig_q) && (pos_q < b_trail_q);

	always_comb begin
		if (pos_q < b_lead_q)
			char_w = dif_pkg::ASCII_SPACE;
		else if (pos_q < b_zero_q)
			char_w = sign_char_q;
		else if (pos_q < b_dig_q)
			char_w = dif_pkg::ASCII_ZERO;
		else if (pos_q < b_trail_q)
			char_w = dif_pkg::ASCII_ZERO + {4'b0, top_dig};
		else
			char_w = dif_pkg::ASCII_SPACE;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 7'd0;
			md_q <= 7'h7f;
			lj_q <= 1'b0;
			fp_q <= 1'b0;
			ss_q <= 1'b0;
			zp_q <= 1'b0;
			lm_q <= dif_pkg::LEN_INT;
			sm_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				dif_pkg::CFG_FIELD_WIDTH:  fw_q <= cfg_data;
				dif_pkg::CFG_MIN_DIGITS:   md_q <= cfg_data;
				dif_pkg::CFG_LEFT_JUSTIFY: lj_q <= cfg_data[0];
				dif_pkg::CFG_FORCE_PLUS:   fp_q <= cfg_data[0];
				dif_pkg::CFG_SPACE_SIGN:   ss_q <= cfg_data[0];
				dif_pkg::CFG_ZERO_PAD:     zp_q <= cfg_data[0];
				dif_pkg::CFG_LENGTH_MODE:  lm_q <= cfg_data[1:0];
				dif_pkg::CFG_SIGNED_MODE:  sm_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dif_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				dif_pkg::ST_IDLE:
					if (in_valid)
						state_q <= dif_pkg::ST_MAG;
				dif_pkg::ST_MAG:
					state_q <= dif_pkg::ST_CONV;
				dif_pkg::ST_CONV:
					if (iter_q == dif_pkg::ITER_W'(1))
						state_q <= dif_pkg::ST_NORM;
				dif_pkg::ST_NORM:
					if (ndig_q == dif_pkg::NDIG_W'(1) || top_dig != 4'd0)
						state_q <= dif_pkg::ST_PREP;
				dif_pkg::ST_PREP:
					state_q <= dif_pkg::ST_BOUND;
				dif_pkg::ST_BOUND:
					state_q <= dif_pkg::ST_EMIT;
				dif_pkg::ST_EMIT:
					if (load_out && is_last)
						state_q <= dif_pkg::ST_IDLE;
				default:
					state_q <= dif_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			dif_pkg::ST_IDLE:
				if (in_valid)
					arg_q <= arg_bits;
			dif_pkg::ST_MAG: begin
				bin_q  <= aligned;
				iter_q <= iters;
				neg_q  <= neg_w;
				bcd_q  <= '0;
				ndig_q <= dif_pkg::NDIG_W'(dif_pkg::BCD_DIGITS);
			end
			dif_pkg::ST_CONV: begin
				bcd_q  <= bcd_n;
				bin_q  <= bin_n;
				iter_q <= iter_q - dif_pkg::ITER_W'(1);
			end
			dif_pkg::ST_NORM:
				if (ndig_q != dif_pkg::NDIG_W'(1) && top_dig == 4'd0) begin
					bcd_q  <= {bcd_q[BW-5:0], 4'b0};
					ndig_q <= ndig_q - dif_pkg::NDIG_W'(1);
				end
			dif_pkg::ST_PREP: begin
				pad_q       <= pad_w[PW-1:0];
				body_q      <= body_w[PW-1:0];
				signlen_q   <= signlen_w;
				zfill_q     <= zp_q & md_q[6] & ~lj_q;
				sign_char_q <= neg_q ? dif_pkg::ASCII_MINUS :
				               fp_q  ? dif_pkg::ASCII_PLUS  : dif_pkg::ASCII_SPACE;
			end
			dif_pkg::ST_BOUND: begin
				b_lead_q  <= lead_w;
				b_zero_q  <= bzero_w;
				b_dig_q   <= bdig_w;
				b_trail_q <= btrail_w;
				b_end_q   <= btrail_w + (lj_q ? pad_q : '0);
				pos_q     <= '0;
			end
			dif_pkg::ST_EMIT:
				if (load_out) begin
					char_q <= char_w;
					last_q <= is_last;
					pos_q  <= pos_q + PW'(1);
					if (is_digit)
						bcd_q <= {bcd_q[BW-5:0], 4'b0};
				end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == dif_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign last_char = last_q;

endmodule

// ===== hdl/dif_checker.sv =====
module dif_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_char,
	input logic        last_char
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
		else $error("stalled output beat changed");

	a_busy_mid_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> !in_ready)
		else $error("input taken in the middle of a field");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted argument");

	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || last_char)
		else $error("character of a new field appeared right after accept");

endmodule

bind decimal_integer_field_formatter dif_checker u_dif_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int FIELD_MAX = 64;
	localparam int WATCHDOG = 4000;
	localparam int RAND_PHASES = 15;
	localparam int PHASE_ITEMS = 30;
	localparam logic [6:0] NO_PREC = 7'h7F;
	localparam logic [6:0] MOST_NEG_PREC = 7'h40;
	localparam logic [1:0] LEN_ALIAS = 2'd3;

	class field_text_sb;
		logic [6:0] fw;
		logic signed [6:0] md;
		bit lj, fp, ss, zp, sgn;
		logic [1:0] len;
		logic [7:0] exp_char[$];
		bit exp_last[$];
		int errors;

		function new();
			fw = '0;
			md = NO_PREC;
			lj = 0;
			fp = 0;
			ss = 0;
			zp = 0;
			len = dif_pkg::LEN_INT;
			sgn = 1;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [6:0] d);
			case (idx)
				dif_pkg::CFG_FIELD_WIDTH:  fw = d;
				dif_pkg::CFG_MIN_DIGITS:   md = d;
				dif_pkg::CFG_LEFT_JUSTIFY: lj = d[0];
				dif_pkg::CFG_FORCE_PLUS:   fp = d[0];
				dif_pkg::CFG_SPACE_SIGN:   ss = d[0];
				dif_pkg::CFG_ZERO_PAD:     zp = d[0];
				dif_pkg::CFG_LENGTH_MODE:  len = d[1:0];
				dif_pkg::CFG_SIGNED_MODE:  sgn = d[0];
				default: ;
			endcase
		endfunction

		function void note_arg(logic [63:0] raw);
			logic [63:0] mag;
			bit neg, has_sign, zfill;
			logic [7:0] sign_ch;
			logic [7:0] digs[$];
			logic [7:0] txt[$];
			int ndig, prec, width, body, total, pad;
			neg = 0;
			has_sign = 0;
			sign_ch = dif_pkg::ASCII_SPACE;
			case (len)
				dif_pkg::LEN_SHORT: begin
					mag = {48'd0, raw[15:0]};
					if (sgn && raw[15]) begin
						neg = 1;
						mag = 64'h1_0000 - mag;
					end
				end
				dif_pkg::LEN_INT: begin
					mag = {32'd0, raw[31:0]};
					if (sgn && raw[31]) begin
						neg = 1;
						mag = 64'h1_0000_0000 - mag;
					end
				end
				default: begin
					mag = raw;
					if (sgn && raw[63]) begin
						neg = 1;
						mag = 64'd0 - mag;
					end
				end
			endcase
			if (sgn) begin
				if (neg) begin
					has_sign = 1;
					sign_ch = dif_pkg::ASCII_MINUS;
				end else if (fp) begin
					has_sign = 1;
					sign_ch = dif_pkg::ASCII_PLUS;
				end else if (ss) begin
					has_sign = 1;
					sign_ch = dif_pkg::ASCII_SPACE;
				end
			end
			do begin
				digs.push_back(dif_pkg::ASCII_ZERO + 8'(mag % 64'd10));
				mag = mag / 64'd10;
			end while (mag != 0);
			ndig = digs.size();
			prec = int'(md);
			if (prec > FIELD_MAX - int'(has_sign))
				prec = FIELD_MAX - int'(has_sign);
			zfill = zp && (md < 0) && !lj;
			width = (fw > FIELD_MAX) ? FIELD_MAX : int'(fw);
			body = (prec > ndig) ? prec : ndig;
			total = int'(has_sign) + body;
			pad = (width > total) ? width - total : 0;
			if (!lj && !zfill)
				repeat (pad) txt.push_back(dif_pkg::ASCII_SPACE);
			if (has_sign)
				txt.push_back(sign_ch);
			if (zfill)
				repeat (pad) txt.push_back(dif_pkg::ASCII_ZERO);
			repeat (body - ndig) txt.push_back(dif_pkg::ASCII_ZERO);
			for (int i = ndig - 1; i >= 0; i--)
				txt.push_back(digs[i]);
			if (lj)
				repeat (pad) txt.push_back(dif_pkg::ASCII_SPACE);
			for (int i = 0; i < txt.size(); i++) begin
				exp_char.push_back(txt[i]);
				exp_last.push_back(i == txt.size() - 1);
			end
		endfunction

		function void check_char(logic [7:0] c, logic l);
			logic [7:0] e;
			bit el;
			if (exp_char.size() == 0) begin
				errors++;
				$display("%0t: char beat with none expected: expected none, actual %h/%b",
					$time, c, l);
				return;
			end
			e = exp_char.pop_front();
			el = exp_last.pop_front();
			if (c !== e) begin
				errors++;
				$display("%0t: out_char expected %h actual %h", $time, e, c);
			end
			if (l !== el) begin
				errors++;
				$display("%0t: last_char expected %b actual %b", $time, el, l);
			end
		endfunction

		function int outstanding();
			return exp_char.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [63:0] arg_bits;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_char;
	logic last_char;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [6:0] cfg_data;

	bit steady = 0;
	int quiet = 0;
	field_text_sb sb = new();

	decimal_integer_field_formatter #(
		.MAX_FIELD(FIELD_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.arg_bits(arg_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.last_char(last_char),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_char(out_char, last_char);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// call on a falling edge; returns on the falling edge after the beat
	task automatic send_arg(input logic [63:0] v);
		while (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		arg_bits <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_arg(v);
		@(negedge clk);
	endtask

	task automatic wait_for_all_chars();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic program_cfg(input logic [6:0] fw, input logic [6:0] md,
			input bit lj, input bit fp, input bit ss, input bit zp,
			input logic [1:0] len, input bit sg);
		logic [6:0] vals[8];
		vals[dif_pkg::CFG_FIELD_WIDTH]  = fw;
		vals[dif_pkg::CFG_MIN_DIGITS]   = md;
		vals[dif_pkg::CFG_LEFT_JUSTIFY] = {6'd0, lj};
		vals[dif_pkg::CFG_FORCE_PLUS]   = {6'd0, fp};
		vals[dif_pkg::CFG_SPACE_SIGN]   = {6'd0, ss};
		vals[dif_pkg::CFG_ZERO_PAD]     = {6'd0, zp};
		vals[dif_pkg::CFG_LENGTH_MODE]  = {5'd0, len};
		vals[dif_pkg::CFG_SIGNED_MODE]  = {6'd0, sg};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= 3'(i);
			cfg_data <= vals[i];
			sb.write_reg(3'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_cfg();
		logic [6:0] fw, md;
		fw = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
		case ($urandom_range(4))
			0: md = NO_PREC;
			1: md = 7'($urandom_range(64, 127));
			2: md = 7'($urandom_range(63));
			default: md = 7'($urandom_range(12));
		endcase
		program_cfg(fw, md, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)),
			1'($urandom_range(1)));
	endtask

	function automatic logic [63:0] pick_arg();
		logic [63:0] v;
		int k;
		k = $urandom_range(63);
		case ($urandom_range(5))
			0, 1: v = {$urandom, $urandom};
			2: v = 64'($urandom_range(20));
			3: v = 64'd0 - 64'($urandom_range(20));
			4: v = (64'd1 << k) - 64'($urandom_range(2));
			default: v = {$urandom, $urandom} >> k;
		endcase
		return v;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		arg_bits = '0;
		cfg_we = 1'b0;
		cfg_idx = dif_pkg::CFG_FIELD_WIDTH;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: signed int, no width, no precision
		send_arg(64'd0);
		send_arg(64'd1);
		send_arg(64'hFFFF_FFFF_FFFF_FFFF);
		send_arg(64'h1234_5678_8000_0000);
		send_arg(64'h0000_0000_7FFF_FFFF);
		wait_for_all_chars();

		// zero with precision 0 still prints a digit
		program_cfg(7'd10, 7'd0, 0, 1, 0, 0, dif_pkg::LEN_LONG, 1);
		send_arg(64'd0);
		send_arg(64'h8000_0000_0000_0000);
		send_arg(64'h7FFF_FFFF_FFFF_FFFF);
		wait_for_all_chars();

		// unsigned ignores plus and space flags
		program_cfg(7'd0, NO_PREC, 0, 1, 1, 0, dif_pkg::LEN_LONG, 0);
		send_arg(64'hFFFF_FFFF_FFFF_FFFF);
		send_arg(64'd42);
		wait_for_all_chars();

		// space sign ahead of zero fill
		program_cfg(7'd8, NO_PREC, 0, 0, 1, 1, dif_pkg::LEN_SHORT, 1);
		send_arg(64'hABCD_0000_0000_8000);
		send_arg(64'h0000_0000_0000_7FFF);
		send_arg(64'd5);
		wait_for_all_chars();

		program_cfg(7'd8, MOST_NEG_PREC, 0, 0, 0, 1, dif_pkg::LEN_SHORT, 0);
		send_arg(64'h0000_0000_0000_FFFF);
		wait_for_all_chars();

		// width beyond the field limit
		program_cfg(7'd127, NO_PREC, 1, 0, 0, 0, dif_pkg::LEN_INT, 1);
		send_arg(64'd0 - 64'd5);
		wait_for_all_chars();

		// widest precision, length code 3 acts as long
		program_cfg(7'd0, 7'd63, 0, 1, 0, 0, LEN_ALIAS, 1);
		send_arg(64'hFFFF_FFFF_FFFF_FFFF);
		send_arg(64'd7);
		wait_for_all_chars();

		program_cfg(7'd12, 7'd5, 0, 0, 0, 1, dif_pkg::LEN_INT, 1);
		send_arg(64'd0 - 64'd42);
		wait_for_all_chars();

		program_cfg(7'd6, NO_PREC, 1, 0, 1, 1, dif_pkg::LEN_INT, 1);
		send_arg(64'd3);
		wait_for_all_chars();

		for (int p = 0; p < RAND_PHASES; p++) begin
			random_cfg();
			steady = (p >= 4 && p <= 6);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 8 && n == PHASE_ITEMS / 2)
					wait_for_all_chars();
				send_arg(pick_arg());
			end
			wait_for_all_chars();
		end
		steady = 0;

		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== decimal_integer_field_formatter.f =====
hdl/dif_pkg.sv
hdl/decimal_integer_field_formatter.sv
hdl/dif_checker.sv
dv/tb.sv
